### hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every rising clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
// next-cycle implication outside reset
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`endif

### hdl/c2aa_pkg.sv
// package: payload types, characters and the codon lookup function
`default_nettype none
package c2aa_pkg;

  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [7:0] base;
    logic       last_base;
  } in_item_t;

  typedef struct packed {
    logic [6:0] residue;
    logic       last_residue;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    logic       has_codon;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic       last;
  } codon_item_t;

  localparam logic [6:0] ResUnknown = 7'h3f; // '?'
  localparam logic [6:0] ResGap     = 7'h7e; // '~'
  localparam logic [6:0] ResAmbig   = 7'h58; // 'X'

  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    if (c >= "a" && c <= "z") begin
      return c - 8'd32;
    end
    return c;
  endfunction

  function automatic logic is_gap(input logic [7:0] c);
    return c == "." || c == "-" || c == "~";
  endfunction

  function automatic logic is_iupac(input logic [7:0] c);
    case (c)
      "A", "C", "G", "T", "U", "R", "Y", "S", "W", "K", "M", "B", "D", "H", "V",
      "N": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic in_four(input logic [7:0] c);
    case (c)
      "A", "B", "C", "D", "G", "H", "K", "M", "N", "R", "S", "T", "V", "W",
      "Y": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic in_pyr(input logic [7:0] c);
    return c == "C" || c == "T" || c == "Y";
  endfunction

  function automatic logic in_pur(input logic [7:0] c);
    return c == "A" || c == "G" || c == "R";
  endfunction

  // table lookup, zero when the codon is absent
  function automatic logic [7:0] lookup(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
    logic [7:0] four;
    logic [7:0] pyr;
    logic [7:0] pur;
    four = 8'd0;
    pyr  = 8'd0;
    pur  = 8'd0;
    if (a == b && b == c && is_gap(a)) return a;
    if (a == "T" && b == "R" && c == "A") return "*";
    if (a == "T" && b == "G" && c == "A") return "*";
    if (a == "T" && b == "G" && c == "G") return "W";
    if (a == "A" && b == "T") begin
      if (c == "G") return "M";
      case (c)
        "A", "C", "H", "M", "T", "W", "Y": return "I";
        default: return 8'd0;
      endcase
    end
    case ({a, b})
      "GC": four = "A";
      "GG": four = "G";
      "CT": four = "L";
      "CC": four = "P";
      "CG": four = "R";
      "TC": four = "S";
      "AC": four = "T";
      "GT": four = "V";
      "TG": pyr = "C";
      "GA": begin pyr = "D"; pur = "E"; end
      "TT": begin pyr = "F"; pur = "L"; end
      "CA": begin pyr = "H"; pur = "Q"; end
      "AA": begin pyr = "N"; pur = "K"; end
      "AG": begin pyr = "S"; pur = "R"; end
      "TA": begin pyr = "Y"; pur = "*"; end
      "YT": pur = "L";
      "MG": pur = "R";
      default: ;
    endcase
    if (four != 8'd0 && in_four(c)) return four;
    if (pyr != 8'd0 && in_pyr(c)) return pyr;
    if (pur != 8'd0 && in_pur(c)) return pur;
    return 8'd0;
  endfunction

  function automatic logic [6:0] translate(input logic [7:0] a, input logic [7:0] b,
                                           input logic [7:0] c);
    logic [7:0] r;
    r = lookup(a, b, c);
    if (r != 8'd0) return r[6:0];
    if (is_gap(a) || is_gap(b) || is_gap(c)) return ResGap;
    if (!is_iupac(a) || !is_iupac(b) || !is_iupac(c)) return ResUnknown;
    return ResAmbig;
  endfunction

endpackage
`default_nettype wire

### hdl/codon_to_amino_acid.sv
// top level of the codon to amino acid translator
// Takes one ASCII base per cycle and gives one residue for every third base,
// plus '?' when the sequence ends inside a codon. Throughput is one base per
// cycle while in_stall is low; an accepted base passes the front's combinational
// classification, a two-entry queue and the registered lookup output.
`default_nettype none
module codon_to_amino_acid #(
  parameter int unsigned QUEUE_DEPTH = c2aa_pkg::QueueDepth
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  c2aa_pkg::in_item_t   in_data,
  output logic                 in_stall,
  output logic                 out_valid,
  output c2aa_pkg::out_item_t  out_data,
  input  wire                  out_stall
);
  import c2aa_pkg::*;

  logic f_valid, f_stall, b_valid, b_stall;
  codon_item_t f_data, b_data;

  c2aa_front u_front (.clk, .rst_n, .in_valid, .in_data, .in_stall,
    .q_valid(f_valid), .q_data(f_data), .q_stall(f_stall));

  c2aa_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (.clk, .rst_n,
    .wr_valid(f_valid), .wr_data(f_data), .wr_stall(f_stall),
    .rd_valid(b_valid), .rd_data(b_data), .rd_stall(b_stall));

  c2aa_back u_back (.clk, .rst_n, .q_valid(b_valid), .q_data(b_data),
    .q_stall(b_stall), .out_valid, .out_data, .out_stall);
endmodule
`default_nettype wire

### hdl/c2aa_front.sv
// front end: case folding and codon assembly
`default_nettype none
module c2aa_front (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  input  c2aa_pkg::in_item_t     in_data,
  output logic                   in_stall,
  output logic                   q_valid,
  output c2aa_pkg::codon_item_t  q_data,
  input  wire                    q_stall
);
  import c2aa_pkg::*;

  logic [7:0] first_r, first_nxt;
  logic [7:0] second_r, second_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [7:0] c;
  logic       acc;

  assign in_stall = q_stall;
  assign acc = in_valid && !q_stall;
  assign c = fold_upper(in_data.base);

  // phase tracking and classification
  always_comb begin
    first_nxt  = first_r;
    second_nxt = second_r;
    phase_nxt  = phase_r;
    q_valid    = 1'b0;
    q_data     = '{has_codon: 1'b0, b1: first_r, b2: second_r, b3: c,
                   last: in_data.last_base};
    if (acc) begin
      if (phase_r == 2'd2) begin
        q_valid          = 1'b1;
        q_data.has_codon = 1'b1;
        phase_nxt        = 2'd0;
      end else begin
        if (phase_r == 2'd0) first_nxt = c;
        else second_nxt = c;
        if (in_data.last_base) begin
          q_valid   = 1'b1;
          phase_nxt = 2'd0;
        end else begin
          phase_nxt = phase_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= 2'd0;
      first_r  <= 8'd0;
      second_r <= 8'd0;
    end else begin
      phase_r  <= phase_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
    end
  end
endmodule
`default_nettype wire

### hdl/c2aa_queue.sv
// short queue between front and back
`default_nettype none
module c2aa_queue #(
  parameter int unsigned DEPTH = c2aa_pkg::QueueDepth
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    wr_valid,
  input  c2aa_pkg::codon_item_t  wr_data,
  output logic                   wr_stall,
  output logic                   rd_valid,
  output c2aa_pkg::codon_item_t  rd_data,
  input  wire                    rd_stall
);
  import c2aa_pkg::*;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  codon_item_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic wr, rd;

  assign wr_stall = (cnt_r == (AW+1)'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && !wr_stall;
  assign rd = rd_valid && !rd_stall;

  // storage write
  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (rd) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end
endmodule
`default_nettype wire

### hdl/c2aa_back.sv
// back end: codon translation into a registered result
`default_nettype none
module c2aa_back (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    q_valid,
  input  c2aa_pkg::codon_item_t  q_data,
  output logic                   q_stall,
  output logic                   out_valid,
  output c2aa_pkg::out_item_t    out_data,
  input  wire                    out_stall
);
  import c2aa_pkg::*;

  logic      valid_r;
  out_item_t data_r;
  logic      load;

  assign q_stall = valid_r && out_stall;
  assign load = q_valid && !q_stall;
  assign out_valid = valid_r;
  assign out_data = data_r;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!q_stall) begin
      valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r.residue <= q_data.has_codon ?
                        translate(q_data.b1, q_data.b2, q_data.b3) : ResUnknown;
      data_r.last_residue <= q_data.last;
    end
  end
endmodule
`default_nettype wire

### hdl/c2aa_checker.sv
// port-level checker for the translator, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module c2aa_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_stall,
  input wire                 out_valid,
  input c2aa_pkg::out_item_t out_data,
  input wire                 out_stall
);
  import c2aa_pkg::*;
  // a stalled result holds
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
  // no result and no input stall right after reset
  `CHK_IMPL(a_nothing_from_idle, clk, rst_n, !$past(rst_n), !out_valid && !in_stall)
  // residue is no lower than '*' (7'h2a), the lowest residue character
  `CHK_IMPL(a_res_range, clk, rst_n, out_valid, out_data.residue >= 7'h2a)
endmodule
bind codon_to_amino_acid c2aa_checker u_chk (.*);
`default_nettype wire
